/* sv/udrb_pkg.sv */
// ----------------------------------------------------------------------------
// udrb_pkg
// Command codes and controller-to-datapath control group for the dual UART
// ring buffer.
// ----------------------------------------------------------------------------
package udrb_pkg;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_LINE_RX  = 2'd0;  // byte from the line into rx queue
  localparam cmd_t CMD_SW_WRITE = 2'd1;  // software byte into tx queue
  localparam cmd_t CMD_SW_READ  = 2'd2;  // software takes byte from rx queue
  localparam cmd_t CMD_TX_READY = 2'd3;  // transmitter takes byte from tx queue

  typedef struct packed {
    logic load;  // capture the incoming item
    logic exec;  // perform the queue operation, register the result
  } ctl_t;

endpackage

/* sv/udrb_ctrl.sv */
// ----------------------------------------------------------------------------
// udrb_ctrl
// Sequencer: accept an item, run it through the datapath, strobe the result.
// ----------------------------------------------------------------------------
module udrb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          out_valid,
  output udrb_pkg::ctl_t ctl
);
  import udrb_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
  assign ctl.load  = (state_r == ST_IDLE) && start;
  assign ctl.exec  = (state_r == ST_EXEC);

endmodule

/* sv/udrb_dp.sv */
// ----------------------------------------------------------------------------
// udrb_dp
// Datapath: rx and tx byte stores, their pointers, the tx interrupt enable and
// the result registers.
// ----------------------------------------------------------------------------
module udrb_dp #(
  parameter int RX_DEPTH = 128,
  parameter int TX_DEPTH = 128
) (
  input  logic           clk,
  input  logic           rst_n,
  input  udrb_pkg::ctl_t ctl,
  input  udrb_pkg::cmd_t in_cmd,
  input  logic [7:0]     in_byte_in,
  output logic           out_ok,
  output logic [7:0]     out_read_byte,
  output logic           out_send_valid,
  output logic [7:0]     out_send_byte,
  output logic           out_tx_irq_enabled
);
  import udrb_pkg::*;

  localparam int RW = (RX_DEPTH > 2) ? $clog2(RX_DEPTH) : 1;
  localparam int TW = (TX_DEPTH > 2) ? $clog2(TX_DEPTH) : 1;
  localparam logic [RW-1:0] RX_LAST = RW'(RX_DEPTH - 1);
  localparam logic [TW-1:0] TX_LAST = TW'(TX_DEPTH - 1);

  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];

  cmd_t       cmd_r;
  logic [7:0] byte_r;

  logic [RW-1:0] rx_wp_r, rx_wp_nxt, rx_rp_r, rx_rp_nxt;
  logic [TW-1:0] tx_wp_r, tx_wp_nxt, tx_rp_r, tx_rp_nxt;
  logic          tx_en_r, tx_en_nxt;
  logic          ok_r, ok_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic          sv_r, sv_nxt;
  logic [7:0]    rx_rdata_r, tx_rdata_r;

  logic [RW-1:0] rx_wp_adv, rx_rp_adv;
  logic [TW-1:0] tx_wp_adv, tx_rp_adv;
  logic          rx_full, rx_empty, tx_full, tx_empty;
  logic          rx_wr, tx_wr;

  assign rx_wp_adv = (rx_wp_r == RX_LAST) ? '0 : rx_wp_r + 1'b1;
  assign rx_rp_adv = (rx_rp_r == RX_LAST) ? '0 : rx_rp_r + 1'b1;
  assign tx_wp_adv = (tx_wp_r == TX_LAST) ? '0 : tx_wp_r + 1'b1;
  assign tx_rp_adv = (tx_rp_r == TX_LAST) ? '0 : tx_rp_r + 1'b1;

  // one slot stays free: full when the advanced write pointer hits the reader
  assign rx_full  = (rx_wp_adv == rx_rp_r);
  assign rx_empty = (rx_wp_r == rx_rp_r);
  assign tx_full  = (tx_wp_adv == tx_rp_r);
  assign tx_empty = (tx_wp_r == tx_rp_r);

  assign rx_wr = ctl.exec && (cmd_r == CMD_LINE_RX) && !rx_full;
  assign tx_wr = ctl.exec && (cmd_r == CMD_SW_WRITE) && !tx_full;

  always_comb begin
    rx_wp_nxt = rx_wp_r;
    rx_rp_nxt = rx_rp_r;
    tx_wp_nxt = tx_wp_r;
    tx_rp_nxt = tx_rp_r;
    tx_en_nxt = tx_en_r;
    ok_nxt    = ok_r;
    rd_ok_nxt = rd_ok_r;
    sv_nxt    = sv_r;
    if (ctl.exec) begin
      ok_nxt    = 1'b0;
      rd_ok_nxt = 1'b0;
      sv_nxt    = 1'b0;
      case (cmd_r)
        CMD_LINE_RX: begin
          if (!rx_full) begin
            rx_wp_nxt = rx_wp_adv;
            ok_nxt    = 1'b1;
          end
        end
        CMD_SW_WRITE: begin
          if (!tx_full) begin
            tx_wp_nxt = tx_wp_adv;
            tx_en_nxt = 1'b1;
            ok_nxt    = 1'b1;
          end
        end
        CMD_SW_READ: begin
          if (!rx_empty) begin
            rx_rp_nxt = rx_rp_adv;
            ok_nxt    = 1'b1;
            rd_ok_nxt = 1'b1;
          end
        end
        default: begin
          if (!tx_empty) begin
            tx_rp_nxt = tx_rp_adv;
            ok_nxt    = 1'b1;
            sv_nxt    = 1'b1;
          end else begin
            tx_en_nxt = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_wp_r <= '0;
      rx_rp_r <= '0;
      tx_wp_r <= '0;
      tx_rp_r <= '0;
      tx_en_r <= 1'b0;
      ok_r    <= 1'b0;
      rd_ok_r <= 1'b0;
      sv_r    <= 1'b0;
    end else begin
      rx_wp_r <= rx_wp_nxt;
      rx_rp_r <= rx_rp_nxt;
      tx_wp_r <= tx_wp_nxt;
      tx_rp_r <= tx_rp_nxt;
      tx_en_r <= tx_en_nxt;
      ok_r    <= ok_nxt;
      rd_ok_r <= rd_ok_nxt;
      sv_r    <= sv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= in_cmd;
      byte_r <= in_byte_in;
    end
  end

  // rx store: one write port, registered read at the read pointer
  always_ff @(posedge clk) begin
    if (rx_wr) rx_mem[rx_wp_r] <= byte_r;
    if (ctl.exec) rx_rdata_r <= rx_mem[rx_rp_r];
  end

  always_ff @(posedge clk) begin
    if (tx_wr) tx_mem[tx_wp_r] <= byte_r;
    if (ctl.exec) tx_rdata_r <= tx_mem[tx_rp_r];
  end

  assign out_ok             = ok_r;
  assign out_read_byte      = rd_ok_r ? rx_rdata_r : 8'd0;
  assign out_send_valid     = sv_r;
  assign out_send_byte      = sv_r ? tx_rdata_r : 8'd0;
  assign out_tx_irq_enabled = tx_en_r;

endmodule

/* sv/uart_dual_ring_buffer.sv */
// After accept the controller steps through EXEC, then DONE, where out_valid
// strobes. Each item passes capture, queue access with registered store read,
// and result strobe; busy stays high through DONE, so items never overlap.
// Reset (rst_n low, synchronous): both queues empty, tx interrupt enable off.
// Store contents are not cleared; only written entries are ever read.
// out_valid strobes for exactly one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
// uart_dual_ring_buffer
// Receive and transmit circular byte queues for a UART link, one command per
// item, one result per item.
// ----------------------------------------------------------------------------
module uart_dual_ring_buffer #(
  parameter int RX_DEPTH = 128,
  parameter int TX_DEPTH = 128
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  udrb_pkg::cmd_t in_cmd,
  input  logic [7:0]     in_byte_in,
  output logic           out_valid,
  output logic           out_ok,
  output logic [7:0]     out_read_byte,
  output logic           out_send_valid,
  output logic [7:0]     out_send_byte,
  output logic           out_tx_irq_enabled
);
  import udrb_pkg::*;

  ctl_t ctl;

  udrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  udrb_dp #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .in_cmd             (in_cmd),
    .in_byte_in         (in_byte_in),
    .out_ok             (out_ok),
    .out_read_byte      (out_read_byte),
    .out_send_valid     (out_send_valid),
    .out_send_byte      (out_send_byte),
    .out_tx_irq_enabled (out_tx_irq_enabled)
  );

`ifndef SYNTHESIS
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("accepted item produced no result strobe");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> $past(out_valid))
    else $error("busy dropped without a result");

  a_send_implies_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_send_valid) |-> (out_ok && !(out_read_byte != 8'd0)))
    else $error("send without ok or with read data");
`endif

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for uart_dual_ring_buffer. A driver issues commands
// through the start/busy handshake and a behavioral copy of both byte queues
// predicts each result. A monitor compares every out_valid strobe against the
// oldest prediction. Stimulus is a short directed run of edge cases, then
// phases that fill and drain each queue so that the full and empty cases
// occur.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import udrb_pkg::*;

  localparam int RX_SLOTS      = 128;
  localparam int TX_SLOTS      = 128;
  localparam int RANDOM_ITEMS  = 1800;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    cmd_t       cmd;
    logic [7:0] data;
    bit         drain_first;  // hold this item until every result is back
  } uart_cmd_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] read_byte;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       irq_en;
  } uart_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  cmd_t       in_cmd = CMD_LINE_RX;
  logic [7:0] in_byte_in = 8'h00;
  logic       out_valid;
  logic       out_ok;
  logic [7:0] out_read_byte;
  logic       out_send_valid;
  logic [7:0] out_send_byte;
  logic       out_tx_irq_enabled;

  uart_cmd_t    pending_cmds[$];
  uart_result_t expected_results[$];
  int           accepted_count = 0;
  int           result_count = 0;
  int           items_sent = 0;
  int           fail_count = 0;

  // queue state kept by the predictor
  logic [7:0] rx_mem [RX_SLOTS];
  logic [7:0] tx_mem [TX_SLOTS];
  int         rx_wr = 0, rx_rd = 0, tx_wr = 0, tx_rd = 0;
  logic       irq_en = 1'b0;

  // coverage tallies for the summary
  int n_line = 0, n_write = 0, n_read = 0, n_tick = 0;
  int rx_drops = 0, tx_drops = 0, empty_reads = 0, empty_ticks = 0;

  uart_dual_ring_buffer #(
    .RX_DEPTH(RX_SLOTS),
    .TX_DEPTH(TX_SLOTS)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_byte_in        (in_byte_in),
    .out_valid         (out_valid),
    .out_ok            (out_ok),
    .out_read_byte     (out_read_byte),
    .out_send_valid    (out_send_valid),
    .out_send_byte     (out_send_byte),
    .out_tx_irq_enabled(out_tx_irq_enabled)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int next_slot(int p, int depth);
    return (p + 1 >= depth) ? 0 : p + 1;
  endfunction

  function automatic uart_result_t predict_queue_op(cmd_t cmd, logic [7:0] data);
    uart_result_t r;
    int           nx;
    r = '0;
    case (cmd)
      CMD_LINE_RX: begin
        n_line++;
        nx = next_slot(rx_wr, RX_SLOTS);
        if (nx != rx_rd) begin
          rx_mem[rx_wr] = data;
          rx_wr = nx;
          r.ok = 1'b1;
        end else begin
          rx_drops++;
        end
      end
      CMD_SW_WRITE: begin
        n_write++;
        nx = next_slot(tx_wr, TX_SLOTS);
        if (nx != tx_rd) begin
          tx_mem[tx_wr] = data;
          tx_wr = nx;
          irq_en = 1'b1;
          r.ok = 1'b1;
        end else begin
          tx_drops++;
        end
      end
      CMD_SW_READ: begin
        n_read++;
        if (rx_wr != rx_rd) begin
          r.read_byte = rx_mem[rx_rd];
          rx_rd = next_slot(rx_rd, RX_SLOTS);
          r.ok = 1'b1;
        end else begin
          empty_reads++;
        end
      end
      default: begin
        n_tick++;
        if (tx_wr != tx_rd) begin
          r.send_byte = tx_mem[tx_rd];
          r.send_valid = 1'b1;
          tx_rd = next_slot(tx_rd, TX_SLOTS);
          r.ok = 1'b1;
        end else begin
          irq_en = 1'b0;
          empty_ticks++;
        end
      end
    endcase
    r.irq_en = irq_en;
    return r;
  endfunction

  // driver: one command per handshake, random gaps outside the quiet window
  always @(posedge clk) begin : drive
    bit        accepting;
    bit        drained;
    bit        gap;
    bit        go;
    uart_cmd_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      accepting = start && !busy;
      if (accepting) begin
        expected_results.push_back(predict_queue_op(in_cmd, in_byte_in));
        accepted_count <= accepted_count + 1;
      end
      if (!start || accepting) begin
        drained = !accepting && (accepted_count == result_count);
        gap = !(items_sent >= 700 && items_sent < 1000) && ($urandom_range(99) < 6);
        go = (pending_cmds.size() != 0) && !gap &&
             !(pending_cmds[0].drain_first && !drained);
        if (go) begin
          nxt = pending_cmds.pop_front();
          in_cmd <= nxt.cmd;
          in_byte_in <= nxt.data;
          items_sent++;
        end
        start <= go;
      end
    end
  end

  // monitor: every strobe must match the oldest prediction
  always @(posedge clk) begin : monitor
    uart_result_t exp_r;
    int           idle_cycles;
    if (rst_n) begin
      if (out_valid) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          $error("result with no command outstanding");
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_ok !== exp_r.ok) begin
            $error("ok mismatch: expected %0d, got %0d", exp_r.ok, out_ok);
            fail_count++;
          end
          if (out_read_byte !== exp_r.read_byte) begin
            $error("read_byte mismatch: expected %02h, got %02h",
                   exp_r.read_byte, out_read_byte);
            fail_count++;
          end
          if (out_send_valid !== exp_r.send_valid) begin
            $error("send_valid mismatch: expected %0d, got %0d",
                   exp_r.send_valid, out_send_valid);
            fail_count++;
          end
          if (out_send_byte !== exp_r.send_byte) begin
            $error("send_byte mismatch: expected %02h, got %02h",
                   exp_r.send_byte, out_send_byte);
            fail_count++;
          end
          if (out_tx_irq_enabled !== exp_r.irq_en) begin
            $error("tx_irq_enabled mismatch: expected %0d, got %0d",
                   exp_r.irq_en, out_tx_irq_enabled);
            fail_count++;
          end
        end
      end
      if (out_valid || (start && !busy)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
          $display("CHECK FAILED");
          $finish;
        end
      end
    end else begin
      idle_cycles = 0;
    end
  end

  task automatic add_cmd(cmd_t cmd, logic [7:0] data, bit drain_first = 1'b0);
    uart_cmd_t c;
    c.cmd = cmd;
    c.data = data;
    c.drain_first = drain_first;
    pending_cmds.push_back(c);
  endtask

  initial begin : stimulus
    int   mode;
    int   len;
    int   total;
    cmd_t favored;
    cmd_t c;

    // directed: field extremes, every command, empty-queue cases
    add_cmd(CMD_LINE_RX, 8'h00);
    add_cmd(CMD_LINE_RX, 8'hFF);
    add_cmd(CMD_LINE_RX, 8'hA5);
    add_cmd(CMD_SW_READ, 8'hFF);
    add_cmd(CMD_SW_READ, 8'h00);
    add_cmd(CMD_SW_READ, 8'h5A);
    add_cmd(CMD_SW_READ, 8'h5A);   // rx empty
    add_cmd(CMD_TX_READY, 8'hFF);  // tx empty, flag already clear
    add_cmd(CMD_SW_WRITE, 8'hFF);
    add_cmd(CMD_SW_WRITE, 8'h00);
    add_cmd(CMD_SW_WRITE, 8'h3C);
    add_cmd(CMD_TX_READY, 8'h00);
    add_cmd(CMD_TX_READY, 8'hFF);
    add_cmd(CMD_TX_READY, 8'h81);
    add_cmd(CMD_TX_READY, 8'h7E);  // tx empty, clears the enable
    add_cmd(CMD_TX_READY, 8'h00);
    add_cmd(CMD_LINE_RX, 8'h5A);
    add_cmd(CMD_SW_WRITE, 8'hC3);
    add_cmd(CMD_SW_READ, 8'h00);
    add_cmd(CMD_TX_READY, 8'h00);

    // random phases, each but mode 4 biased toward one command so queues hit full/empty
    total = 0;
    while (total < RANDOM_ITEMS) begin
      if (total == 0) begin
        mode = 0;
        len = 200;
      end else if (total < 400) begin
        mode = 2;
        len = 200;
      end else begin
        mode = $urandom_range(4);
        len = $urandom_range(260, 60);
      end
      case (mode)
        0:       favored = CMD_LINE_RX;
        1:       favored = CMD_SW_READ;
        2:       favored = CMD_SW_WRITE;
        default: favored = CMD_TX_READY;
      endcase
      for (int i = 0; i < len && total < RANDOM_ITEMS; i++) begin
        if (mode != 4 && $urandom_range(99) < 70)
          c = favored;
        else
          c = cmd_t'($urandom_range(3));
        add_cmd(c, 8'($urandom_range(255)), total == 0 || total == 900);
        total++;
      end
    end

    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || start || accepted_count != result_count)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      fail_count++;
    end

    $display("Ran %0d items: %0d line bytes (%0d rx drops), %0d writes (%0d tx drops)",
             accepted_count, n_line, rx_drops, n_write, tx_drops);
    $display("  %0d reads (%0d on empty rx), %0d tx ticks (%0d on empty tx)",
             n_read, empty_reads, n_tick, empty_ticks);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
